### src/lrukv_pkg.sv
package lrukv_pkg;

	localparam int MAX_ENTRIES_DEF = 16;

	localparam int CAP_W   = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// word index of each register (paddr[2])
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic signed [31:0] MISS_VALUE = -32'sd1;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               found;
	} rsp_t;

endpackage

### src/lrukv_ram.sv
module lrukv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
//
// Request channel (req_valid/req_ready/req_data): one get or put per item.
// Response channel (rsp_valid/rsp_ready/rsp_data): one item per get, none
// per put. A get that misses returns -1 with found clear.
// Configuration: APB write of capacity_in_use at byte address 0; zero acts
// as one, values above MAX_ENTRIES act as MAX_ENTRIES.
//
// Throughput: one request per cycle while no get is held behind a waiting
// response. Each request sits in the input register, where all keys are
// compared in parallel and the recency ranks, keys and occupancy are
// updated; a get hit reads the value RAM, whose registered output feeds the
// response. Response valid is registered when the get leaves the input register.
// Stall: while a response waits, puts keep flowing; a get waits in the
// input register, with ready held low, until the response slot frees.
// Reset clears all valid marks, ranks and occupancy at once (no sweep) and
// sets the capacity to 16; keys and values are not cleared.
module lru_key_value_cache #(
	parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       req_valid,
	output logic                       req_ready,
	input  lrukv_pkg::req_t            req_data,

	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output lrukv_pkg::rsp_t            rsp_data,

	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lrukv_pkg::PADDR_W-1:0] paddr,
	input  logic [lrukv_pkg::PDATA_W-1:0] pwdata,
	output logic [lrukv_pkg::PDATA_W-1:0] prdata,
	output logic                       pready
);
	import lrukv_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

	// configuration
	logic [CAP_W-1:0] cap_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CAPACITY) begin
			prdata = {{(PDATA_W-CAP_W){1'b0}}, cap_q};
		end
	end

	// entry state
	logic signed [31:0] key_q   [MAX_ENTRIES];
	logic [IDX_W-1:0]   rank_q  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [OCC_W-1:0]   occ_q;

	// input register
	logic valid_s1;
	req_t item_s1;

	// response stage
	logic valid_s2;
	logic found_s2;
	logic [31:0] ram_rdata;

	logic s1_adv;
	logic is_put;

	assign is_put    = (item_s1.cmd == CMD_PUT);
	assign s1_adv    = valid_s1 && (is_put || !valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req_data;
		end
	end

	// lookup
	logic [MAX_ENTRIES-1:0] hit_vec;
	logic [MAX_ENTRIES-1:0] victim_vec;
	logic                   hit;
	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       victim_idx;
	logic [IDX_W-1:0]       hit_rank;
	logic [OCC_W-1:0]       eff_cap;
	logic [OCC_W-1:0]       occ_m1;
	logic                   full;
	logic [IDX_W-1:0]       tgt_idx;
	logic [IDX_W-1:0]       prom_rank;
	logic                   do_update;
	logic                   insert;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = OCC_W'(1);
		end else if (int'(cap_q) > MAX_ENTRIES) begin
			eff_cap = OCC_W'(MAX_ENTRIES);
		end else begin
			eff_cap = OCC_W'(cap_q);
		end
	end

	assign full   = (occ_q >= eff_cap);
	assign occ_m1 = occ_q - OCC_W'(1);

	// valid ranks are always 0..occ-1, so the least recent entry has rank occ-1
	always_comb begin
		hit_idx    = '0;
		victim_idx = '0;
		hit_rank   = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_vec[i]    = valid_q[i] && (key_q[i] == item_s1.key);
			victim_vec[i] = valid_q[i] && (rank_q[i] == occ_m1[IDX_W-1:0]);
			if (hit_vec[i]) begin
				hit_idx  = hit_idx | IDX_W'(i);
				hit_rank = hit_rank | rank_q[i];
			end
			if (victim_vec[i]) begin
				victim_idx = victim_idx | IDX_W'(i);
			end
		end
	end

	assign hit = |hit_vec;

	// entries fill from index 0 and are never freed except by reset, so the
	// first free slot is the occupancy
	always_comb begin
		if (hit) begin
			tgt_idx   = hit_idx;
			prom_rank = hit_rank;
		end else if (full) begin
			tgt_idx   = victim_idx;
			prom_rank = occ_m1[IDX_W-1:0];
		end else begin
			tgt_idx   = occ_q[IDX_W-1:0];
			prom_rank = occ_q[IDX_W-1:0];
		end
	end

	assign do_update = s1_adv && (hit || is_put);
	assign insert    = s1_adv && is_put && !hit && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (do_update) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (IDX_W'(i) == tgt_idx) begin
						rank_q[i]  <= '0;
						valid_q[i] <= 1'b1;
					end else if (valid_q[i] && (rank_q[i] < prom_rank)) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
			end
			if (insert) begin
				occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && is_put && !hit) begin
			key_q[tgt_idx] <= item_s1.key;
		end
	end

	lrukv_ram #(
		.WIDTH(32),
		.DEPTH(MAX_ENTRIES),
		.AW   (IDX_W)
	) u_values (
		.clk  (clk),
		.we   (s1_adv && is_put),
		.waddr(tgt_idx),
		.wdata(item_s1.value),
		.re   (s1_adv && !is_put && hit),
		.raddr(hit_idx),
		.rdata(ram_rdata)
	);

	// response stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv && !is_put) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && !is_put) begin
			found_s2 <= hit;
		end
	end

	assign rsp_valid           = valid_s2;
	assign rsp_data.found      = found_s2;
	assign rsp_data.read_value = found_s2 ? signed'(ram_rdata) : MISS_VALUE;

	// checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= MAX_ENTRIES)
		else $error("occupancy above entry count");

	a_valid_occ: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("valid marks disagree with occupancy");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(hit_vec))
		else $error("key present in more than one entry");

	a_hit_keeps_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && hit) |=> $stable(occ_q))
		else $error("occupancy changed on a hit");

endmodule
